// File: design/bcrm_pkg.sv
// -----------------------------------------------------------------------------
// bcrm_pkg : shared types and functions for the ball circle redraw block
// pitch marking test, visible point mask and the queue entry layout
// -----------------------------------------------------------------------------
package bcrm_pkg;

   localparam logic [3:0] RADIUS_RESET = 4'd3;
   localparam logic [3:0] MAX_STEP_Y   = 4'd10;

   typedef struct packed {
      logic [7:0] old_x;
      logic [7:0] old_y;
      logic [7:0] new_x;
      logic [7:0] new_y;
   } centers_type;

   localparam logic [7:0] ARC_COL [15] = '{
      8'd106, 8'd105, 8'd104, 8'd103, 8'd102, 8'd101, 8'd101, 8'd100,
      8'd100, 8'd99,  8'd99,  8'd99,  8'd98,  8'd98,  8'd98
   };

   function automatic logic on_marking(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] m;
      logic [7:0] f;
      logic [7:0] a;
      logic       r;
      m = (x <= 8'd118) ? x : 8'(8'd236 - x);
      f = (y > 8'd63) ? 8'(8'd126 - y) : y;
      a = 8'(f - 8'd47);
      if (x < 8'd20 || x > 8'd219 || x == 8'd118) begin
         r = 1'b1;
      end else if ((x == 8'd47 || x == 8'd191) && y >= 8'd33 && y <= 8'd92) begin
         r = 1'b1;
      end else if ((x == 8'd27 || x == 8'd211) && y >= 8'd45 && y <= 8'd80) begin
         r = 1'b1;
      end else if ((y == 8'd92 || y == 8'd33) && (x >= 8'd192 || x <= 8'd46)) begin
         r = 1'b1;
      end else if ((y == 8'd45 || y == 8'd80) &&
                   ((x >= 8'd20 && x <= 8'd26) || x >= 8'd212)) begin
         r = 1'b1;
      end else if (y >= 8'd62 && y <= 8'd64 &&
                   (x == 8'd37 || x == 8'd38 || x == 8'd200 || x == 8'd201)) begin
         r = 1'b1;
      end else if (y < 8'd43 || y > 8'd83) begin
         r = 1'b0;
      end else if (f == 8'd43) begin
         r = (m >= 8'd114);
      end else if (f == 8'd44) begin
         r = (m >= 8'd111 && m <= 8'd113);
      end else if (f == 8'd45) begin
         r = (m == 8'd109 || m == 8'd110);
      end else if (f == 8'd46) begin
         r = (m == 8'd107 || m == 8'd108);
      end else if (f >= 8'd47 && f <= 8'd61) begin
         r = (m == ARC_COL[a[3:0]]);
      end else begin
         r = (m == 8'd98 || m == 8'd117);
      end
      return r;
   endfunction

   function automatic logic [7:0] visible_mask(input logic [7:0] cx, input logic [7:0] cy,
                                               input logic o, input logic [3:0] y);
      logic [7:0] px;
      logic [7:0] mx;
      logic [7:0] py;
      logic [7:0] my;
      logic [7:0] qx;
      logic [7:0] nx;
      logic [7:0] qy;
      logic [7:0] ny;
      logic [7:0] mask;
      px = cx + {7'd0, o};
      mx = cx - {7'd0, o};
      py = cy + {4'd0, y};
      my = cy - {4'd0, y};
      qx = cx + {4'd0, y};
      nx = cx - {4'd0, y};
      qy = cy + {7'd0, o};
      ny = cy - {7'd0, o};
      mask[0] = !on_marking(px, py);
      mask[1] = !on_marking(mx, py);
      mask[2] = !on_marking(mx, my);
      mask[3] = !on_marking(px, my);
      mask[4] = !on_marking(qx, qy);
      mask[5] = !on_marking(nx, qy);
      mask[6] = !on_marking(nx, ny);
      mask[7] = !on_marking(qx, ny);
      return mask;
   endfunction

endpackage

// File: design/bcrm_front.sv
// -----------------------------------------------------------------------------
// bcrm_front : request intake
// pairs each new center with the previous one and queues the pair
// -----------------------------------------------------------------------------
module bcrm_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // new_x, new_y
   output logic                 head_valid,
   output bcrm_pkg::centers_type head,
   input  logic                 head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bcrm_pkg::centers_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [7:0]       prev_x_ff;
   logic [7:0]       prev_y_ff;
   logic             push;
   logic             pop;

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head       = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         if (push) begin
            queue_ff[wr_ptr_ff] <= '{old_x: prev_x_ff, old_y: prev_y_ff,
                                     new_x: req_tdata[7:0], new_y: req_tdata[15:8]};
            prev_x_ff <= req_tdata[7:0];
            prev_y_ff <= req_tdata[15:8];
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: design/bcrm_walk.sv
// -----------------------------------------------------------------------------
// bcrm_walk : midpoint octant walker, one word per cycle unless rsp stalls
// erase and draw for thickness 0 and 1 at each step
// -----------------------------------------------------------------------------
module bcrm_walk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           radius,
   input  logic                 head_valid,
   input  bcrm_pkg::centers_type head,
   output logic                 head_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // center_x, center_y, thick_offset,
                                             // octant_offset, point_mask, zero fill
   output logic                 rsp_tuser,   // pixel_value
   output logic                 rsp_tlast
);

   logic                  busy_ff;
   bcrm_pkg::centers_type cen_ff;
   logic signed [5:0]     x_ff;
   logic [3:0]            y_ff;
   logic signed [9:0]     err_ff;
   logic signed [7:0]     xchg_ff;
   logic [5:0]            ychg_ff;
   logic [1:0]            sub_ff;

   logic                  rsp_valid_ff;
   logic [7:0]            out_cx_ff;
   logic [7:0]            out_cy_ff;
   logic                  out_o_ff;
   logic [3:0]            out_y_ff;
   logic [7:0]            out_mask_ff;
   logic                  out_pix_ff;
   logic                  out_last_ff;

   logic signed [9:0]     err_mid;
   logic                  dec;
   logic signed [5:0]     x_in;
   logic [4:0]            y_in;
   logic signed [9:0]     err_in;
   logic signed [7:0]     xchg_in;
   logic [5:0]            ychg_in;
   logic                  cont;
   logic                  adv;
   logic [7:0]            cur_cx;
   logic [7:0]            cur_cy;

   always_comb begin
      err_mid = err_ff + $signed({4'd0, ychg_ff});
      dec     = ($signed({err_mid, 1'b0}) + 11'(xchg_ff)) > 11'sd0;
      y_in    = {1'b0, y_ff} + 5'd1;
      ychg_in = ychg_ff + 6'd2;
      x_in    = dec ? x_ff - 6'sd1 : x_ff;
      err_in  = dec ? err_mid + 10'(xchg_ff) : err_mid;
      xchg_in = dec ? xchg_ff + 8'sd2 : xchg_ff;
      cont    = (x_in >= $signed({1'b0, y_in})) && (y_in <= {1'b0, bcrm_pkg::MAX_STEP_Y});
      cur_cx  = sub_ff[0] ? cen_ff.new_x : cen_ff.old_x;
      cur_cy  = sub_ff[0] ? cen_ff.new_y : cen_ff.old_y;
   end

   assign adv      = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign head_pop = !busy_ff && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (adv) begin
            rsp_valid_ff <= 1'b1;
            out_cx_ff    <= cur_cx;
            out_cy_ff    <= cur_cy;
            out_o_ff     <= sub_ff[1];
            out_y_ff     <= y_ff;
            out_mask_ff  <= bcrm_pkg::visible_mask(cur_cx, cur_cy, sub_ff[1], y_ff);
            out_pix_ff   <= sub_ff[0];
            out_last_ff  <= (sub_ff == 2'd3) && !cont;
            sub_ff       <= sub_ff + 2'd1;
            if (sub_ff == 2'd3) begin
               if (cont) begin
                  x_ff    <= x_in;
                  y_ff    <= y_in[3:0];
                  err_ff  <= err_in;
                  xchg_ff <= xchg_in;
                  ychg_ff <= ychg_in;
               end else begin
                  busy_ff <= 1'b0;
               end
            end
         end else if (head_pop) begin
            busy_ff <= 1'b1;
            cen_ff  <= head;
            x_ff    <= $signed({2'd0, radius});
            y_ff    <= '0;
            err_ff  <= '0;
            xchg_ff <= 8'sd1 - $signed({3'd0, radius, 1'b0});
            ychg_ff <= 6'd1;
            sub_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, out_mask_ff, out_y_ff, out_o_ff, out_cy_ff, out_cx_ff};
   assign rsp_tuser  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_y_ff <= bcrm_pkg::MAX_STEP_Y)
      else $error("octant offset past last step");

   a_draw_follows_erase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tready && !out_pix_ff |=> rsp_valid_ff && out_pix_ff)
      else $error("erase word not followed by draw word");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      adv && sub_ff == 2'd3 && !cont |=> !busy_ff && out_last_ff)
      else $error("walk did not end on last word");

   a_last_on_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_last_ff |-> out_pix_ff && out_o_ff)
      else $error("last word is not the thick draw word");

endmodule

// File: design/ball_circle_redraw_masked_top.sv
// -----------------------------------------------------------------------------
// ball_circle_redraw_masked_top : ball redraw rasterizer
// erases the old ball circle and draws the new one, masking pitch markings
//
//   port group  dir  word
//   req_*       in   new ball center (new_x, new_y)
//   rsp_*       out  one erase or draw word per octant step and thickness
//   csr_*       in   ball_radius write
//
// the walker takes a new center pair only while idle, then gives one word per
// cycle unless rsp stalls: 4 * steps words, steps = octant steps of the radius,
// at most 11; the rate is set by the result register, one word per cycle
// synchronous reset: radius 3, previous center 0,0, queue empty
// a stalled rsp side holds the walker; req keeps filling the center queue
// -----------------------------------------------------------------------------
module ball_circle_redraw_masked_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // new_x, new_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // center_x, center_y, thick_offset,
                                     // octant_offset, point_mask, zero fill
   output logic        rsp_tuser,    // pixel_value
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data   // ball_radius
);

   logic [3:0]            radius_ff;
   logic                  head_valid;
   bcrm_pkg::centers_type head;
   logic                  head_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bcrm_pkg::RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   bcrm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   bcrm_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .radius     (radius_ff),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/ball_redraw_checker.sv
// -----------------------------------------------------------------------------
// ball_redraw_checker : scoreboard for the ball circle redraw block
// tracks the radius register and the previous center, walks the circle octant
// for every accepted center word and compares each pixel word field by field
// -----------------------------------------------------------------------------
module ball_redraw_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // new_x, new_y
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // center_x, center_y, thick_offset,
                                     // octant_offset, point_mask, zero fill
   input  logic        rsp_tuser,    // pixel_value
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,  // ball_radius
   output int          mismatches,
   output int          outstanding,
   output int          words_checked
);

   typedef struct packed {
      logic [7:0] cx;
      logic [7:0] cy;
      logic       thick;
      logic [3:0] oct;
      logic [7:0] mask;
      logic       pix;
      logic       tail;
   } pixel_word_type;

   int rim_col [15] = '{106, 105, 104, 103, 102, 101, 101, 100, 100, 99, 99, 99,
                        98, 98, 98};

   pixel_word_type expected_words [$];
   logic [3:0]  radius;
   logic [7:0]  prev_x;
   logic [7:0]  prev_y;
   int          fail_tally;
   int          words_seen;

   function automatic bit pitch_mark(input int px, input int py);
      int mx;
      int fy;
      mx = (px <= 118) ? px : 236 - px;
      fy = (py > 63) ? 126 - py : py;
      if (px < 20 || px > 219 || px == 118) return 1'b1;
      if ((px == 47 || px == 191) && py >= 33 && py <= 92) return 1'b1;
      if ((px == 27 || px == 211) && py >= 45 && py <= 80) return 1'b1;
      if ((py == 92 || py == 33) && (px >= 192 || px <= 46)) return 1'b1;
      if ((py == 45 || py == 80) && ((px >= 20 && px <= 26) || px >= 212)) return 1'b1;
      if (py >= 62 && py <= 64 && (px == 37 || px == 38 || px == 200 || px == 201))
         return 1'b1;
      if (py < 43 || py > 83) return 1'b0;
      // center circle, folded onto its upper left quarter
      case (fy)
         43: return mx >= 114;
         44: return mx >= 111 && mx <= 113;
         45: return mx == 109 || mx == 110;
         46: return mx == 107 || mx == 108;
         default: begin
            if (fy >= 47 && fy <= 61) return mx == rim_col[fy - 47];
            return mx == 98 || mx == 117;
         end
      endcase
   endfunction

   function automatic logic [7:0] visible_points(input logic [7:0] cx, input logic [7:0] cy,
                                                 input int o, input int y);
      int         dx [8];
      int         dy [8];
      logic [7:0] m;
      dx = '{o, -o, -o, o, y, -y, -y, y};
      dy = '{y, y, -y, -y, o, o, -o, -o};
      for (int k = 0; k < 8; k++) begin
         m[k] = !pitch_mark((int'(cx) + dx[k]) & 255, (int'(cy) + dy[k]) & 255);
      end
      return m;
   endfunction

   // octant steps of the midpoint walk, capped at 11
   function automatic int octant_steps(input int r);
      int x;
      int y;
      int xchg;
      int ychg;
      int err;
      x = r;
      y = 0;
      xchg = 1 - 2 * r;
      ychg = 1;
      err = 0;
      while (x >= y && y < 11) begin
         y++;
         err += ychg;
         ychg += 2;
         if (2 * err + xchg > 0) begin
            x--;
            err += xchg;
            xchg += 2;
         end
      end
      return y;
   endfunction

   task automatic predict_redraw(input logic [7:0] nx, input logic [7:0] ny);
      int             steps;
      pixel_word_type w;
      steps = octant_steps(int'(radius));
      for (int s = 0; s < steps; s++) begin
         for (int o = 0; o < 2; o++) begin
            for (int p = 0; p < 2; p++) begin
               w.cx    = p ? nx : prev_x;
               w.cy    = p ? ny : prev_y;
               w.thick = o[0];
               w.oct   = s[3:0];
               w.mask  = visible_points(w.cx, w.cy, o, s);
               w.pix   = p[0];
               w.tail  = (s == steps - 1) && (o == 1) && (p == 1);
               expected_words.push_back(w);
            end
         end
      end
      prev_x = nx;
      prev_y = ny;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_tally++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_word_type w;
      if (reset) begin
         radius = bcrm_pkg::RADIUS_RESET;
         prev_x = 8'd0;
         prev_y = 8'd0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) radius = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: data %h user %b last %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_tally++;
            end else begin
               w = expected_words.pop_front();
               check_field("center_x", int'(w.cx), int'(rsp_tdata[7:0]));
               check_field("center_y", int'(w.cy), int'(rsp_tdata[15:8]));
               check_field("thick_offset", int'(w.thick), int'(rsp_tdata[16]));
               check_field("octant_offset", int'(w.oct), int'(rsp_tdata[20:17]));
               check_field("point_mask", int'(w.mask), int'(rsp_tdata[28:21]));
               check_field("pixel_value", int'(w.pix), int'(rsp_tuser));
               check_field("last", int'(w.tail), int'(rsp_tlast));
               words_seen++;
            end
         end
         if (req_tvalid && req_tready) predict_redraw(req_tdata[7:0], req_tdata[15:8]);
      end
      mismatches    <= fail_tally;
      outstanding   <= expected_words.size();
      words_checked <= words_seen;
   end

endmodule

// File: tb/ball_circle_redraw_masked_top_tb.sv
// -----------------------------------------------------------------------------
// ball_circle_redraw_masked_top_tb : testbench for the ball redraw rasterizer
// sends directed centers on the pitch markings and at the wrap edges, then
// random centers over many radius settings, with bursty input and a stalling
// output; the checker predicts every pixel word and counts mismatches
// -----------------------------------------------------------------------------
module ball_circle_redraw_masked_top_tb;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BEAT} ready_mode_type;

   localparam int RANDOM_CENTERS = 389;
   localparam int STALL_LIMIT    = 4000;
   localparam int DIRECTED       = 21;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = 16'd0;    // new_x, new_y
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;              // center_x, center_y, thick_offset,
                                        // octant_offset, point_mask, zero fill
   logic        rsp_tuser;              // pixel_value
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = 4'd0;     // ball_radius

   int          mismatches;
   int          outstanding;
   int          words_checked;

   ready_mode_type ready_mode = READY_ALWAYS;
   int          mode_left  = 0;
   int          idle_cycles = 0;
   int          burst_left  = 1;
   bit          valid_up    = 1'b0;
   int          centers_sent = 0;
   int          radius_writes = 0;
   logic [3:0]  radius_now = bcrm_pkg::RADIUS_RESET;
   logic [7:0]  last_x = 8'd0;
   logic [7:0]  last_y = 8'd0;

   int dir_x [DIRECTED] = '{0, 255, 255, 0, 118, 47, 27, 37, 200, 20, 219, 98, 191,
                            118, 5, 118, 0, 250, 47, 211, 138};
   int dir_y [DIRECTED] = '{0, 255, 0, 255, 63, 60, 62, 63, 63, 45, 80, 63, 92,
                            43, 250, 63, 0, 3, 33, 80, 63};
   int dir_r [DIRECTED] = '{3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3,
                            0, 0, 15, 15, 15, 15, 1, 1};
   int radius_plan [6] = '{15, 0, 7, 1, 12, 4};

   always #4 clock = ~clock;

   ball_circle_redraw_masked_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ball_redraw_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   // receiver backpressure pattern
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(16, 120);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
         default:      rsp_tready <= (mode_left % 6) < 3;
      endcase
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("** ball_circle_redraw_masked_top: FAILED **");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] x, input logic [7:0] y);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      valid_up = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      centers_sent++;
      last_x = x;
      last_y = y;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(20, 40);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every expected word has come back
   task automatic drain();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_radius(input logic [3:0] r);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radius_now = r;
      radius_writes++;
   endtask

   function automatic logic [15:0] pick_center();
      logic [7:0] x;
      logic [7:0] y;
      case ($urandom_range(0, 9))
         0, 1: begin
            x = 8'($urandom_range(0, 255));
            y = 8'($urandom_range(0, 255));
         end
         2: begin
            x = 8'($urandom_range(0, 1) ? $urandom_range(0, 18) : $urandom_range(237, 255));
            y = 8'($urandom_range(0, 1) ? $urandom_range(0, 18) : $urandom_range(237, 255));
         end
         3: begin
            x = last_x;
            y = last_y;
         end
         default: begin
            x = 8'($urandom_range(14, 225));
            y = 8'($urandom_range(27, 99));
         end
      endcase
      return {y, x};
   endfunction

   initial begin
      int          phase;
      int          burst;
      logic [15:0] c;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED; i++) begin
         if (dir_r[i] != radius_now) set_radius(4'(dir_r[i]));
         send_word(8'(dir_x[i]), 8'(dir_y[i]));
      end

      while (centers_sent < DIRECTED + RANDOM_CENTERS) begin
         set_radius(4'(phase < 6 ? radius_plan[phase] : $urandom_range(0, 15)));
         phase++;
         burst = $urandom_range(20, 50);
         if (burst > DIRECTED + RANDOM_CENTERS - centers_sent) begin
            burst = DIRECTED + RANDOM_CENTERS - centers_sent;
         end
         repeat (burst) begin
            if ($urandom_range(0, 29) == 0) drain();
            c = pick_center();
            send_word(c[7:0], c[15:8]);
         end
      end

      drain();
      repeat (60) @(posedge clock);

      $display("covered %0d centers over %0d radius writes (0 and 15 included),",
               centers_sent, radius_writes);
      $display("%0d pixel words checked, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("** ball_circle_redraw_masked_top: PASSED **");
      end else begin
         $display("** ball_circle_redraw_masked_top: FAILED **");
      end
      $finish;
   end

endmodule
